[hdl/pmfa_pkg.sv]
`default_nettype none
package pmfa_pkg;

  localparam int FRAME_POINTS = 307200;
  localparam int MAX_FRAMES   = 16;
  localparam int IDX_W        = 19;
  localparam int ADDR_W       = $clog2(FRAME_POINTS);
  localparam int CFG_W        = 5;
  localparam int FIG_W        = $clog2(MAX_FRAMES);
  localparam int CNT_W        = 5;
  localparam int SUM_W        = 21;   // 31 samples of a 16-bit value
  localparam int NSUM_W       = 20;   // 31 samples of a Q1.14 value
  localparam int RECIP_SH     = 26;   // sum magnitude bits plus divisor bits
  localparam int RECIP_W      = 27;
  localparam int PROD_W       = SUM_W + RECIP_W;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd5;
  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

  typedef struct packed {
    logic        [IDX_W-1:0] pixel_index;
    logic                    point_valid;
    logic signed [15:0]      pos_x;
    logic signed [15:0]      pos_y;
    logic signed [15:0]      pos_z;
    logic        [31:0]      color;
    logic                    normal_valid;
    logic signed [15:0]      norm_x;
    logic signed [15:0]      norm_y;
    logic signed [15:0]      norm_z;
  } in_item_t;

  typedef struct packed {
    logic        [IDX_W-1:0] out_index;
    logic                    avg_point_valid;
    logic signed [15:0]      avg_x;
    logic signed [15:0]      avg_y;
    logic signed [15:0]      avg_z;
    logic        [31:0]      avg_color;
    logic                    avg_normal_valid;
    logic signed [15:0]      avg_nx;
    logic signed [15:0]      avg_ny;
    logic signed [15:0]      avg_nz;
  } out_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  psum_x;
    logic signed [SUM_W-1:0]  psum_y;
    logic signed [SUM_W-1:0]  psum_z;
    logic signed [NSUM_W-1:0] nsum_x;
    logic signed [NSUM_W-1:0] nsum_y;
    logic signed [NSUM_W-1:0] nsum_z;
    logic        [CNT_W-1:0]  pcnt;
    logic        [CNT_W-1:0]  ncnt;
    logic        [31:0]       first_color;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef logic [RECIP_W-1:0] recip_t;

  // Rounded-up reciprocals of the counts, scaled by two to the RECIP_SH.
  localparam recip_t RECIP [32] = '{
    27'd0,
    27'((2**26 + 0) / 1),   27'((2**26 + 1) / 2),   27'((2**26 + 2) / 3),
    27'((2**26 + 3) / 4),   27'((2**26 + 4) / 5),   27'((2**26 + 5) / 6),
    27'((2**26 + 6) / 7),   27'((2**26 + 7) / 8),   27'((2**26 + 8) / 9),
    27'((2**26 + 9) / 10),  27'((2**26 + 10) / 11), 27'((2**26 + 11) / 12),
    27'((2**26 + 12) / 13), 27'((2**26 + 13) / 14), 27'((2**26 + 14) / 15),
    27'((2**26 + 15) / 16), 27'((2**26 + 16) / 17), 27'((2**26 + 17) / 18),
    27'((2**26 + 18) / 19), 27'((2**26 + 19) / 20), 27'((2**26 + 20) / 21),
    27'((2**26 + 21) / 22), 27'((2**26 + 22) / 23), 27'((2**26 + 23) / 24),
    27'((2**26 + 24) / 25), 27'((2**26 + 25) / 26), 27'((2**26 + 26) / 27),
    27'((2**26 + 27) / 28), 27'((2**26 + 28) / 29), 27'((2**26 + 29) / 30),
    27'((2**26 + 30) / 31)
  };

endpackage
`default_nettype wire

[hdl/pmfa_in_if.sv]
`default_nettype none
interface pmfa_in_if;
  logic               valid;
  logic               ready;
  pmfa_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/pmfa_out_if.sv]
`default_nettype none
interface pmfa_out_if;
  logic                valid;
  logic                ready;
  pmfa_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/pmfa_ram.sv]
`default_nettype none
module pmfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hdl/masked_point_frame_averager_core.sv]
`default_nettype none
// Channel    Direction  Contents
// in_pt      sink       one camera point per transfer, raster order
// out_pt     source     one averaged point per transfer, last frame of a group
// cfg_*      write      frames_to_average, taken whenever cfg_we is high
//
// A point can be taken in every cycle unless a stall holds stage 1. The store read is
// issued at the point's transfer edge; stage 1 then does the read-modify-write, the
// magnitudes and the reciprocal lookup, stage 2 the multiplies and stage 3 restores the
// signs into the output register, which drives out_pt.valid. The pixel store has one
// write and one read port, and a point that follows the same pixel directly takes the
// freshly written entry from a bypass register. Reset clears the frame counter and all
// stage valid bits and sets the group length to CFG_RESET; the store itself is not
// cleared.
// A stall on out_pt backs up stage by stage and nothing is lost or repeated. Points that
// close no group still leave stage 1 while stage 2 waits; a closing point holds stage 1
// and with it the input.
module masked_point_frame_averager_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  pmfa_in_if.sink                         in_pt,
  pmfa_out_if.source                      out_pt,
  input  wire logic                       cfg_we,
  input  wire logic [pmfa_pkg::CFG_W-1:0] cfg_data
);

  localparam int NL = 6;

  logic [pmfa_pkg::CFG_W-1:0] cfg_r;
  logic [pmfa_pkg::FIG_W-1:0] fig_r;
  logic [pmfa_pkg::CFG_W-1:0] grp_len;
  logic                       in_last, in_acc, in_range;

  // Stage 1: read-modify-write of the pixel entry.
  logic                  s1_v_r, s1_clr_r, s1_last_r, byp_hit_r;
  pmfa_pkg::in_item_t    s1_item_r;
  pmfa_pkg::entry_t      byp_r, s1_base, s1_new;
  logic [pmfa_pkg::ENTRY_W-1:0] rd_data;
  logic                  s1_adv, p_add, n_add;

  // Stage 2: magnitudes and reciprocals. Stage 3: products.
  logic                  s2_v_r, s3_v_r, o_v_r;
  logic                  s2_free, s3_free, o_free;
  logic [pmfa_pkg::IDX_W-1:0] s2_idx_r, s3_idx_r;
  logic                  s2_pv_r, s2_nv_r, s3_pv_r, s3_nv_r;
  logic [31:0]           s2_col_r, s3_col_r;
  logic [NL-1:0]         s2_neg_r, s3_neg_r, sum_neg;
  logic [pmfa_pkg::SUM_W-1:0]  sum_ext [NL];
  logic [pmfa_pkg::SUM_W-1:0]  s2_mag_r [NL];
  pmfa_pkg::recip_t            s2_rp_r, s2_rn_r;
  logic [pmfa_pkg::PROD_W-1:0] s3_prod_r [NL];
  logic [15:0]                 quo [NL];
  pmfa_pkg::out_item_t         o_r;

  always_comb begin
    if (cfg_r == '0) begin
      grp_len = pmfa_pkg::CFG_W'(1);
    end else if (cfg_r > pmfa_pkg::CFG_W'(pmfa_pkg::MAX_FRAMES)) begin
      grp_len = pmfa_pkg::CFG_W'(pmfa_pkg::MAX_FRAMES);
    end else begin
      grp_len = cfg_r;
    end
  end

  assign in_last  = ({1'b0, fig_r} + pmfa_pkg::CFG_W'(1)) >= grp_len;
  assign in_acc   = in_pt.valid && in_pt.ready;
  assign in_range = in_pt.data.pixel_index < pmfa_pkg::IDX_W'(pmfa_pkg::FRAME_POINTS);

  assign o_free  = !o_v_r || out_pt.ready;
  assign s3_free = !s3_v_r || o_free;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_adv  = s1_v_r && (!s1_last_r || s2_free);
  assign in_pt.ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pmfa_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_data;
    end
  end

  // The frame counter moves on the last pixel of every frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fig_r <= '0;
    end else if (in_acc &&
                 in_pt.data.pixel_index == pmfa_pkg::IDX_W'(pmfa_pkg::FRAME_POINTS - 1)) begin
      fig_r <= in_last ? '0 : fig_r + pmfa_pkg::FIG_W'(1);
    end
  end

  pmfa_ram #(
    .WIDTH (pmfa_pkg::ENTRY_W),
    .DEPTH (pmfa_pkg::FRAME_POINTS)
  ) u_store (
    .clk       (clk),
    .wr_en     (s1_adv),
    .wr_addr   (s1_item_r.pixel_index[pmfa_pkg::ADDR_W-1:0]),
    .wr_data   (s1_new),
    .rd_en     (in_acc),
    .rd_addr   (in_pt.data.pixel_index[pmfa_pkg::ADDR_W-1:0]),
    .rd_data_r (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_pt.ready) begin
      s1_v_r <= in_pt.valid && in_range;
    end
  end

  // The bypass catches the entry written at the very edge of the read, which
  // the store itself would still return in its old form.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_pt.data;
      s1_clr_r  <= fig_r == '0;
      s1_last_r <= in_last;
      byp_hit_r <= s1_adv && (s1_item_r.pixel_index == in_pt.data.pixel_index);
    end
    if (s1_adv) begin
      byp_r <= s1_new;
    end
  end

  always_comb begin
    if (s1_clr_r) begin
      s1_base = '0;
    end else if (byp_hit_r) begin
      s1_base = byp_r;
    end else begin
      s1_base = pmfa_pkg::entry_t'(rd_data);
    end
    p_add  = s1_item_r.point_valid && (s1_base.pcnt != pmfa_pkg::COUNT_MAX);
    n_add  = s1_item_r.normal_valid && (s1_base.ncnt != pmfa_pkg::COUNT_MAX);
    s1_new = s1_base;
    if (p_add) begin
      if (s1_base.pcnt == '0) begin
        s1_new.first_color = s1_item_r.color;
      end
      s1_new.psum_x = s1_base.psum_x + pmfa_pkg::SUM_W'(s1_item_r.pos_x);
      s1_new.psum_y = s1_base.psum_y + pmfa_pkg::SUM_W'(s1_item_r.pos_y);
      s1_new.psum_z = s1_base.psum_z + pmfa_pkg::SUM_W'(s1_item_r.pos_z);
      s1_new.pcnt   = s1_base.pcnt + pmfa_pkg::CNT_W'(1);
    end
    if (n_add) begin
      s1_new.nsum_x = s1_base.nsum_x + pmfa_pkg::NSUM_W'(s1_item_r.norm_x);
      s1_new.nsum_y = s1_base.nsum_y + pmfa_pkg::NSUM_W'(s1_item_r.norm_y);
      s1_new.nsum_z = s1_base.nsum_z + pmfa_pkg::NSUM_W'(s1_item_r.norm_z);
      s1_new.ncnt   = s1_base.ncnt + pmfa_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    sum_ext[0] = s1_new.psum_x;
    sum_ext[1] = s1_new.psum_y;
    sum_ext[2] = s1_new.psum_z;
    sum_ext[3] = pmfa_pkg::SUM_W'(s1_new.nsum_x);
    sum_ext[4] = pmfa_pkg::SUM_W'(s1_new.nsum_y);
    sum_ext[5] = pmfa_pkg::SUM_W'(s1_new.nsum_z);
    for (int i = 0; i < NL; i++) begin
      sum_neg[i] = sum_ext[i][pmfa_pkg::SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s2_free) s2_v_r <= s1_v_r && s1_last_r;
      if (s3_free) s3_v_r <= s2_v_r;
      if (o_free)  o_v_r  <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_idx_r <= s1_item_r.pixel_index;
      s2_pv_r  <= s1_new.pcnt != '0;
      s2_nv_r  <= s1_new.ncnt != '0;
      s2_col_r <= s1_new.first_color;
      s2_neg_r <= sum_neg;
      s2_rp_r  <= pmfa_pkg::RECIP[s1_new.pcnt];
      s2_rn_r  <= pmfa_pkg::RECIP[s1_new.ncnt];
      for (int i = 0; i < NL; i++) begin
        s2_mag_r[i] <= sum_neg[i] ? -sum_ext[i] : sum_ext[i];
      end
    end
    if (s3_free) begin
      s3_idx_r <= s2_idx_r;
      s3_pv_r  <= s2_pv_r;
      s3_nv_r  <= s2_nv_r;
      s3_col_r <= s2_col_r;
      s3_neg_r <= s2_neg_r;
      for (int i = 0; i < NL; i++) begin
        s3_prod_r[i] <= pmfa_pkg::PROD_W'(s2_mag_r[i]) *
                        pmfa_pkg::PROD_W'((i < 3) ? s2_rp_r : s2_rn_r);
      end
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      quo[i] = s3_prod_r[i][pmfa_pkg::RECIP_SH +: 16];
      if (s3_neg_r[i]) quo[i] = -quo[i];
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      o_r.out_index        <= s3_idx_r;
      o_r.avg_point_valid  <= s3_pv_r;
      o_r.avg_x            <= s3_pv_r ? quo[0] : '0;
      o_r.avg_y            <= s3_pv_r ? quo[1] : '0;
      o_r.avg_z            <= s3_pv_r ? quo[2] : '0;
      o_r.avg_color        <= s3_pv_r ? s3_col_r : '0;
      o_r.avg_normal_valid <= s3_nv_r;
      o_r.avg_nx           <= s3_nv_r ? quo[3] : '0;
      o_r.avg_ny           <= s3_nv_r ? quo[4] : '0;
      o_r.avg_nz           <= s3_nv_r ? quo[5] : '0;
    end
  end

  assign out_pt.valid = o_v_r;
  assign out_pt.data  = o_r;

  a_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_pt.valid && !out_pt.data.avg_point_valid |->
      out_pt.data.avg_color == '0 && out_pt.data.avg_x == '0)
    else $error("result without a valid position carries data");

  a_no_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_pt.valid && !out_pt.data.avg_normal_valid |-> out_pt.data.avg_nx == '0)
    else $error("result without a valid normal carries data");

  a_group_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last &&
    in_pt.data.pixel_index == pmfa_pkg::IDX_W'(pmfa_pkg::FRAME_POINTS - 1) |=> fig_r == '0)
    else $error("group did not close on the last frame");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |-> s1_item_r.pixel_index < pmfa_pkg::IDX_W'(pmfa_pkg::FRAME_POINTS))
    else $error("store write beyond the frame");

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  // Per-pixel accumulator as the averager keeps it between frames.
  typedef struct {
    int          psum [3];
    int          nsum [3];
    int unsigned pcnt;
    int unsigned ncnt;
    logic [31:0] first_color;
  } pixel_acc_t;

  // One row of the directed table. A row either writes the group length or
  // offers a point; where the outcome is obvious the expected average is typed in.
  typedef struct {
    bit                             is_cfg;
    logic [pmfa_pkg::CFG_W-1:0]     cfg_val;
    pmfa_pkg::in_item_t             pt;
    bit                             typed;
    pmfa_pkg::out_item_t            avg;
  } dir_row_t;

  localparam int LAST_PIXEL  = pmfa_pkg::FRAME_POINTS - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 12;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [pmfa_pkg::CFG_W-1:0] cfg_data;

  pmfa_in_if  in_if ();
  pmfa_out_if out_if ();

  masked_point_frame_averager_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pt    (in_if),
    .out_pt   (out_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Shadow state of the averager.
  logic [pmfa_pkg::CFG_W-1:0] group_len_reg;
  int unsigned      frame_pos;
  pixel_acc_t       pixel_acc [int];
  // Pixels whose entry has been written at least once since reset; only these
  // may be revisited in a frame other than the first of a group.
  bit               written_pixels [int];

  pmfa_pkg::out_item_t avg_queue [$];
  dir_row_t            dir_rows [$];
  int                  error_count;
  int                  sender_idle_pct;
  int                  receiver_stall_pct;
  longint              cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_row(dir_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  // Effective group length: zero behaves as one, anything above the maximum
  // is clamped to the maximum.
  function automatic int unsigned frames_per_group();
    int unsigned n;
    n = group_len_reg;
    if (n == 0) n = 1;
    if (n > pmfa_pkg::MAX_FRAMES) n = pmfa_pkg::MAX_FRAMES;
    return n;
  endfunction

  // Advances the shadow state by one point and returns 1 when the point
  // closes its group, with the averaged point in avg.
  function automatic bit average_point(input pmfa_pkg::in_item_t pt,
                                       output pmfa_pkg::out_item_t avg);
    int         idx;
    bit         closing;
    pixel_acc_t acc;
    idx     = pt.pixel_index;
    closing = (frame_pos + 1) >= frames_per_group();
    avg     = '0;
    if (idx >= pmfa_pkg::FRAME_POINTS) return 1'b0;
    // The first frame of a group starts every sample afresh.
    if (frame_pos == 0 || !pixel_acc.exists(idx)) begin
      acc = '{psum: '{0, 0, 0}, nsum: '{0, 0, 0}, pcnt: 0, ncnt: 0, first_color: '0};
    end else begin
      acc = pixel_acc[idx];
    end
    if (pt.point_valid && acc.pcnt < pmfa_pkg::COUNT_MAX) begin
      if (acc.pcnt == 0) acc.first_color = pt.color;
      acc.psum[0] += $signed(pt.pos_x);
      acc.psum[1] += $signed(pt.pos_y);
      acc.psum[2] += $signed(pt.pos_z);
      acc.pcnt++;
    end
    if (pt.normal_valid && acc.ncnt < pmfa_pkg::COUNT_MAX) begin
      acc.nsum[0] += $signed(pt.norm_x);
      acc.nsum[1] += $signed(pt.norm_y);
      acc.nsum[2] += $signed(pt.norm_z);
      acc.ncnt++;
    end
    pixel_acc[idx] = acc;
    written_pixels[idx] = 1'b1;
    if (closing) begin
      avg.out_index = pt.pixel_index;
      if (acc.pcnt != 0) begin
        // Integer division in SystemVerilog truncates toward zero.
        avg.avg_point_valid = 1'b1;
        avg.avg_x     = 16'(acc.psum[0] / int'(acc.pcnt));
        avg.avg_y     = 16'(acc.psum[1] / int'(acc.pcnt));
        avg.avg_z     = 16'(acc.psum[2] / int'(acc.pcnt));
        avg.avg_color = acc.first_color;
      end
      if (acc.ncnt != 0) begin
        avg.avg_normal_valid = 1'b1;
        avg.avg_nx = 16'(acc.nsum[0] / int'(acc.ncnt));
        avg.avg_ny = 16'(acc.nsum[1] / int'(acc.ncnt));
        avg.avg_nz = 16'(acc.nsum[2] / int'(acc.ncnt));
      end
    end
    if (idx == LAST_PIXEL) frame_pos = closing ? 0 : frame_pos + 1;
    return closing;
  endfunction

  function automatic pmfa_pkg::in_item_t make_point(int idx, bit pv, int x, int y, int z,
                                                    logic [31:0] col, bit nv,
                                                    int nx, int ny, int nz);
    pmfa_pkg::in_item_t pt;
    pt.pixel_index  = pmfa_pkg::IDX_W'(idx);
    pt.point_valid  = pv;
    pt.pos_x        = 16'(x);
    pt.pos_y        = 16'(y);
    pt.pos_z        = 16'(z);
    pt.color        = col;
    pt.normal_valid = nv;
    pt.norm_x       = 16'(nx);
    pt.norm_y       = 16'(ny);
    pt.norm_z       = 16'(nz);
    return pt;
  endfunction

  function automatic pmfa_pkg::out_item_t make_avg(int idx, bit pv, int x, int y, int z,
                                                   logic [31:0] col, bit nv,
                                                   int nx, int ny, int nz);
    pmfa_pkg::in_item_t pt;
    pt = make_point(idx, pv, x, y, z, col, nv, nx, ny, nz);
    return pmfa_pkg::out_item_t'(pt);
  endfunction

  // Offers one point and waits for its transfer. The valid line is left high
  // afterwards so that back-to-back points never lower and raise it in one step.
  task automatic send_point(input pmfa_pkg::in_item_t pt, input bit typed,
                            input pmfa_pkg::out_item_t typed_avg);
    pmfa_pkg::out_item_t avg;
    bit                  has_avg;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    has_avg = average_point(pt, avg);
    if (typed) begin
      if (!has_avg) begin
        $display("%0t: directed point %0d expected an average but none is due", $time,
                 pt.pixel_index);
        error_count++;
      end
      avg = typed_avg;
    end
    if (has_avg) avg_queue = {avg_queue, avg};
    in_if.valid <= 1'b1;
    in_if.data  <= pt;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Waits until every expected average has arrived and the pipeline has had
  // time to finish points that produce nothing, then writes the group length.
  task automatic write_group_len(input logic [pmfa_pkg::CFG_W-1:0] val);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (avg_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we        <= 1'b0;
    group_len_reg  = val;
  endtask

  function automatic pmfa_pkg::in_item_t random_point(int idx);
    return make_point(idx, $urandom_range(3) != 0, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(3) != 0, int'($urandom_range(32768)) - 16384,
                      int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384);
  endfunction

  // Picks a pixel for the current frame. In the first frame of a group any
  // pixel but the last may be used; later frames revisit only pixels written before.
  function automatic int pick_pixel();
    int keys [$];
    if (frame_pos == 0) begin
      case ($urandom_range(9))
        0:       return $urandom_range(LAST_PIXEL - 1);
        1:       return LAST_PIXEL - 1;
        default: return $urandom_range(47);
      endcase
    end
    foreach (written_pixels[k]) keys = {keys, k};
    return keys[$urandom_range(keys.size() - 1)];
  endfunction

  // One frame: a few points, sometimes out-of-range noise, now and then a long
  // burst on one pixel to drive its counts into saturation, and finally the
  // point that ends the frame.
  task automatic send_frame();
    int n;
    int idx;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        send_point(random_point($urandom_range(pmfa_pkg::FRAME_POINTS,
                                               2**pmfa_pkg::IDX_W - 1)), 1'b0, '0);
      end else begin
        send_point(random_point(pick_pixel()), 1'b0, '0);
      end
    end
    if (frame_pos != 0 && $urandom_range(29) == 0) begin
      idx = pick_pixel();
      repeat ($urandom_range(32, 40)) send_point(random_point(idx), 1'b0, '0);
    end
    send_point(random_point(LAST_PIXEL), 1'b0, '0);
  endtask

  // Result side: checks each transfer against the oldest expectation and
  // stalls at random.
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    pmfa_pkg::out_item_t exp_avg;
    pmfa_pkg::out_item_t act_avg;
    if (rst_n && out_if.valid && out_if.ready) begin
      act_avg = out_if.data;
      if (avg_queue.size() == 0) begin
        $display("%0t: unexpected averaged point, expected none actual %h", $time, act_avg);
        error_count++;
      end else begin
        exp_avg = avg_queue.pop_front();
        check_field("out_index", exp_avg.out_index, act_avg.out_index);
        check_field("avg_point_valid", exp_avg.avg_point_valid, act_avg.avg_point_valid);
        check_field("avg_x", exp_avg.avg_x, act_avg.avg_x);
        check_field("avg_y", exp_avg.avg_y, act_avg.avg_y);
        check_field("avg_z", exp_avg.avg_z, act_avg.avg_z);
        check_field("avg_color", exp_avg.avg_color, act_avg.avg_color);
        check_field("avg_normal_valid", exp_avg.avg_normal_valid, act_avg.avg_normal_valid);
        check_field("avg_nx", exp_avg.avg_nx, act_avg.avg_nx);
        check_field("avg_ny", exp_avg.avg_ny, act_avg.avg_ny);
        check_field("avg_nz", exp_avg.avg_nz, act_avg.avg_nz);
      end
    end
    out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [pmfa_pkg::CFG_W-1:0] phase_lens [12];
    int              sent;
    int              frames;
    int              phase;
    phase_lens = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd1, 5'd5, 5'd6, 5'd4,
                   5'd16, 5'd2};
    error_count        = 0;
    group_len_reg      = pmfa_pkg::CFG_RESET;
    frame_pos          = 0;
    sender_idle_pct    = 29;
    receiver_stall_pct = 61;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_data     <= '0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. With a group of one frame every point is averaged alone,
    // so the expected result is the point itself with invalid parts zeroed.
    add_row('{1'b1, 5'd1, '0, 1'b0, '0});
    add_row('{1'b0, '0,
      make_point(0, 1, 32767, -32768, 0, 32'hFFFF_FFFF, 1, 16384, -16384, 0), 1'b1,
      make_avg(0, 1, 32767, -32768, 0, 32'hFFFF_FFFF, 1, 16384, -16384, 0)});
    add_row('{1'b0, '0,
      make_point(1, 1, -32768, 32767, -1, 32'h0, 1, -16384, 16384, 1), 1'b1,
      make_avg(1, 1, -32768, 32767, -1, 32'h0, 1, -16384, 16384, 1)});
    // No valid position: position and colour come back as zero.
    add_row('{1'b0, '0,
      make_point(2, 0, 100, 200, 300, 32'h1234_5678, 1, 5, -6, 7), 1'b1,
      make_avg(2, 0, 0, 0, 0, 32'h0, 1, 5, -6, 7)});
    // No valid normal: the normal comes back as zero.
    add_row('{1'b0, '0,
      make_point(3, 1, -7, 8, -9, 32'hA5A5_5A5A, 0, 1000, 2000, 3000), 1'b1,
      make_avg(3, 1, -7, 8, -9, 32'hA5A5_5A5A, 0, 0, 0, 0)});
    add_row('{1'b0, '0,
      make_point(4, 0, 1, 2, 3, 32'h5A5A_A5A5, 0, 4, 5, 6), 1'b1,
      make_avg(4, 0, 0, 0, 0, 32'h0, 0, 0, 0, 0)});
    // Indices beyond the frame are ignored altogether.
    add_row('{1'b0, '0, make_point(pmfa_pkg::FRAME_POINTS, 1, 1, 1, 1, 1, 1, 1, 1, 1),
      1'b0, '0});
    add_row('{1'b0, '0, make_point(2**pmfa_pkg::IDX_W - 1, 1, 1, 1, 1, 1, 1, 1, 1, 1),
      1'b0, '0});
    add_row('{1'b0, '0,
      make_point(LAST_PIXEL, 1, 32767, 32767, 32767, 32'h8000_0001, 1, -16384, -16384, -16384),
      1'b1,
      make_avg(LAST_PIXEL, 1, 32767, 32767, 32767, 32'h8000_0001, 1, -16384, -16384, -16384)});
    // Two-frame groups: sums of mixed signs truncate toward zero.
    add_row('{1'b1, 5'd2, '0, 1'b0, '0});
    add_row('{1'b0, '0, make_point(0, 1, -3, 3, 1, 32'hC0DE, 1, -3, 3, 1), 1'b0, '0});
    add_row('{1'b0, '0, make_point(LAST_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    add_row('{1'b0, '0, make_point(0, 1, -2, 2, 1, 32'hBEEF, 1, -2, 2, 1), 1'b0, '0});
    add_row('{1'b0, '0, make_point(LAST_PIXEL, 0, 0, 0, 0, 0, 1, 9, 9, 9), 1'b0, '0});
    // A longer group shortened after its second frame closes on the next frame.
    add_row('{1'b1, 5'd4, '0, 1'b0, '0});
    add_row('{1'b0, '0, make_point(5, 0, 0, 0, 0, 0, 1, 11, 12, 13), 1'b0, '0});
    add_row('{1'b0, '0, make_point(LAST_PIXEL, 1, 4, 4, 4, 4, 1, 4, 4, 4), 1'b0, '0});
    add_row('{1'b0, '0, make_point(5, 1, 50, 60, 70, 32'hF00D, 0, 0, 0, 0), 1'b0, '0});
    add_row('{1'b0, '0, make_point(LAST_PIXEL, 1, 5, 5, 5, 5, 1, 5, 5, 5), 1'b0, '0});
    add_row('{1'b1, 5'd2, '0, 1'b0, '0});
    add_row('{1'b0, '0, make_point(5, 1, 51, 61, 71, 32'hFEED, 1, 1, 1, 1), 1'b0, '0});
    add_row('{1'b0, '0, make_point(LAST_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    // A length of zero behaves as one.
    add_row('{1'b1, 5'd0, '0, 1'b0, '0});
    add_row('{1'b0, '0, make_point(7, 1, 9, -9, 9, 32'h0707_0707, 1, 1, 2, 3),
      1'b1, make_avg(7, 1, 9, -9, 9, 32'h0707_0707, 1, 1, 2, 3)});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_group_len(dir_rows[i].cfg_val);
      end else begin
        send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].avg);
      end
    end

    // Random part: phases of whole groups, some ending part way through a
    // group so that the next length takes effect mid-group.
    sent  = 0;
    phase = 0;
    while (sent < 1500) begin
      if (sent >= 1000) begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end else if (sent >= 500) begin
        sender_idle_pct    = 61;
        receiver_stall_pct = 29;
      end
      // Writing the length waits for the pipeline to empty, so the sender
      // holds off here until every expected average has been transferred.
      write_group_len(phase_lens[phase % 12]);
      frames = $urandom_range(1, 2 * frames_per_group() + 1);
      repeat (frames) begin
        send_frame();
        sent += 5;
      end
      phase++;
    end

    in_if.valid <= 1'b0;
    while (avg_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
